// File: hdl/stpg_pkg.sv
// stpg_pkg: shared types and constants for the stepper trapezoid pulse generator
// depends on nothing; used by stpg_cfg_regs, stpg_step_core and the top level
`default_nettype none

package stpg_pkg;

  // configuration port geometry
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TOP_PERIOD     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MOVE_STEPS     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MOVE_DIRECTION = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_DIR     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RAMP_STEPS     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RAMP_INCREMENT = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PULSE_WIDTH    = 3'd6;

  // field widths
  localparam int unsigned TOP_PERIOD_W = 24;
  localparam int unsigned MOVE_STEPS_W = 16;
  localparam int unsigned RAMP_STEPS_W = 8;
  localparam int unsigned RAMP_INC_W   = 16;
  localparam int unsigned PULSE_W      = 10;

  // reset values
  localparam logic [TOP_PERIOD_W-1:0] TOP_PERIOD_RST = 24'd1000;
  localparam logic [MOVE_STEPS_W-1:0] MOVE_STEPS_RST = 16'd0;
  localparam logic [RAMP_STEPS_W-1:0] RAMP_STEPS_RST = 8'd16;
  localparam logic [RAMP_INC_W-1:0]   RAMP_INC_RST   = 16'd100;
  localparam logic [PULSE_W-1:0]      PULSE_RST      = 10'd10;

  // width of the start period sum: top period plus ramp_steps * increment
  localparam int unsigned START_SUM_W = TOP_PERIOD_W + 1;

  typedef struct packed {
    logic [TOP_PERIOD_W-1:0] top_period_us;
    logic [MOVE_STEPS_W-1:0] move_steps;
    logic                    move_direction;
    logic                    invert_direction;
    logic [RAMP_STEPS_W-1:0] ramp_steps;
    logic [RAMP_INC_W-1:0]   ramp_increment_us;
    logic [PULSE_W-1:0]      pulse_width_us;
  } stpg_cfg_t;

endpackage

`default_nettype wire

// File: hdl/stpg_cfg_regs.sv
// stpg_cfg_regs: configuration register file written through the plain write port
// depends on stpg_pkg
`default_nettype none

module stpg_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [stpg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [stpg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output stpg_pkg::stpg_cfg_t                   cfg
);

  stpg_pkg::stpg_cfg_t cfg_r;
  stpg_pkg::stpg_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        stpg_pkg::REG_TOP_PERIOD: begin
          cfg_nxt.top_period_us = cfg_wdata[stpg_pkg::TOP_PERIOD_W-1:0];
        end
        stpg_pkg::REG_MOVE_STEPS: begin
          cfg_nxt.move_steps = cfg_wdata[stpg_pkg::MOVE_STEPS_W-1:0];
        end
        stpg_pkg::REG_MOVE_DIRECTION: begin
          cfg_nxt.move_direction = cfg_wdata[0];
        end
        stpg_pkg::REG_INVERT_DIR: begin
          cfg_nxt.invert_direction = cfg_wdata[0];
        end
        stpg_pkg::REG_RAMP_STEPS: begin
          cfg_nxt.ramp_steps = cfg_wdata[stpg_pkg::RAMP_STEPS_W-1:0];
        end
        stpg_pkg::REG_RAMP_INCREMENT: begin
          cfg_nxt.ramp_increment_us = cfg_wdata[stpg_pkg::RAMP_INC_W-1:0];
        end
        stpg_pkg::REG_PULSE_WIDTH: begin
          cfg_nxt.pulse_width_us = cfg_wdata[stpg_pkg::PULSE_W-1:0];
        end
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.top_period_us     <= stpg_pkg::TOP_PERIOD_RST;
      cfg_r.move_steps        <= stpg_pkg::MOVE_STEPS_RST;
      cfg_r.move_direction    <= 1'b0;
      cfg_r.invert_direction  <= 1'b0;
      cfg_r.ramp_steps        <= stpg_pkg::RAMP_STEPS_RST;
      cfg_r.ramp_increment_us <= stpg_pkg::RAMP_INC_RST;
      cfg_r.pulse_width_us    <= stpg_pkg::PULSE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: hdl/stpg_step_core.sv
// stpg_step_core: step timing state and its single-pass update for one transaction
// depends on stpg_pkg
`default_nettype none

module stpg_step_core #(
  parameter int unsigned TIME_WIDTH  = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   fire,
  input  wire logic                   func,
  input  wire logic [TIME_WIDTH-1:0]  now_us,
  input  stpg_pkg::stpg_cfg_t         cfg,
  output logic                        step_level,
  output logic                        step_started,
  output logic [COUNT_WIDTH-1:0]      steps_done,
  output logic [TIME_WIDTH-1:0]       period_now_us
);

  localparam int unsigned LOAD_W =
    (TIME_WIDTH > stpg_pkg::START_SUM_W) ? TIME_WIDTH : stpg_pkg::START_SUM_W;
  localparam int unsigned CMP_W =
    ((COUNT_WIDTH > stpg_pkg::MOVE_STEPS_W) ? COUNT_WIDTH : stpg_pkg::MOVE_STEPS_W) + 1;
  localparam int unsigned PROD_W = stpg_pkg::RAMP_STEPS_W + stpg_pkg::RAMP_INC_W;

  logic [TIME_WIDTH-1:0]  last_step_time_r, last_step_time_nxt;
  logic                   pulse_high_r, pulse_high_nxt;
  logic [TIME_WIDTH-1:0]  period_r, period_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;

  logic [PROD_W-1:0]      ramp_prod;
  logic [LOAD_W-1:0]      start_sum;
  logic [TIME_WIDTH-1:0]  start_period;
  logic [TIME_WIDTH-1:0]  base_period;
  logic [COUNT_WIDTH-1:0] base_count;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic                   started;
  logic [TIME_WIDTH-1:0]  inc_ext;
  logic [TIME_WIDTH:0]    grow_sum;
  logic                   ramp_up;
  logic                   ramp_down;
  logic [CMP_W-1:0]       count_ext;
  logic [CMP_W-1:0]       ramp_ext;
  logic [CMP_W-1:0]       move_ext;
  logic [stpg_pkg::RAMP_STEPS_W:0] ramp_twice;

  // starting period of a move, saturated to the time width
  always_comb begin
    ramp_prod = PROD_W'(cfg.ramp_steps) * PROD_W'(cfg.ramp_increment_us);
    start_sum = LOAD_W'(cfg.top_period_us) + LOAD_W'(ramp_prod);
    if (start_sum > LOAD_W'({TIME_WIDTH{1'b1}})) begin
      start_period = {TIME_WIDTH{1'b1}};
    end else begin
      start_period = start_sum[TIME_WIDTH-1:0];
    end
  end

  always_comb begin
    base_period = func ? start_period : period_r;
    base_count  = func ? '0 : count_r;
    elapsed     = now_us - last_step_time_r;
    started     = !pulse_high_r && (elapsed >= base_period);

    count_ext  = CMP_W'(base_count);
    ramp_ext   = CMP_W'(cfg.ramp_steps);
    move_ext   = CMP_W'(cfg.move_steps);
    ramp_twice = {cfg.ramp_steps, 1'b0};
    ramp_up    = (count_ext < ramp_ext) &&
                 ((stpg_pkg::MOVE_STEPS_W + 1)'(cfg.move_steps) >
                  (stpg_pkg::MOVE_STEPS_W + 1)'(ramp_twice));
    ramp_down  = (count_ext + ramp_ext) > move_ext;

    inc_ext  = TIME_WIDTH'(cfg.ramp_increment_us);
    grow_sum = (TIME_WIDTH + 1)'(base_period) + (TIME_WIDTH + 1)'(inc_ext);

    last_step_time_nxt = last_step_time_r;
    pulse_high_nxt     = pulse_high_r;
    period_nxt         = base_period;
    count_nxt          = base_count;

    if (started) begin
      pulse_high_nxt     = 1'b1;
      last_step_time_nxt = now_us;
      if (ramp_up) begin
        period_nxt = (base_period >= inc_ext) ? (base_period - inc_ext) : '0;
      end else if (ramp_down) begin
        period_nxt = grow_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : grow_sum[TIME_WIDTH-1:0];
      end
      if (base_count != {COUNT_WIDTH{1'b1}}) begin
        count_nxt = base_count + 1'b1;
      end
    end else if (pulse_high_r &&
                 (elapsed >= TIME_WIDTH'(cfg.pulse_width_us))) begin
      pulse_high_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_step_time_r <= '0;
      pulse_high_r     <= 1'b0;
      period_r         <= TIME_WIDTH'(stpg_pkg::TOP_PERIOD_RST);
      count_r          <= '0;
    end else if (fire) begin
      last_step_time_r <= last_step_time_nxt;
      pulse_high_r     <= pulse_high_nxt;
      period_r         <= period_nxt;
      count_r          <= count_nxt;
    end
  end

  assign step_level    = pulse_high_nxt;
  assign step_started  = started;
  assign steps_done    = count_nxt;
  assign period_now_us = period_nxt;

endmodule

`default_nettype wire

// File: hdl/stepper_trapezoid_pulse_generator.sv
// stepper_trapezoid_pulse_generator: top level with input register, step core and
// result register; depends on stpg_pkg, stpg_cfg_regs and stpg_step_core
`default_nettype none

// Step pulse generator with a trapezoidal speed ramp. Every input transaction
// carries the current microsecond time (and optionally a begin-move command)
// and produces exactly one result transaction with the step pin level, a
// step-started flag, the direction pin, the steps taken in the move and the
// current step period. A move starts at top_period_us + ramp_steps *
// ramp_increment_us, shortens by one increment per step over the first
// ramp_steps steps (only when move_steps exceeds twice the ramp), and grows by
// one increment per step once steps taken plus ramp_steps exceed move_steps,
// saturating; stepping never stops by itself. One transaction is taken per
// clock cycle while the result channel does not stall; each one passes the
// input register, the step core and then the result register. The rate is set
// by the state update in the step core, which every transaction passes
// through once. Configuration registers must only be written while no
// transaction is in flight.
module stepper_trapezoid_pulse_generator #(
  parameter int unsigned TIME_WIDTH  = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration write port
  input  wire logic                             cfg_wr_en,
  input  wire logic [stpg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [stpg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_func,
  input  wire logic [TIME_WIDTH-1:0]            in_now_us,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_step_level,
  output logic                                  out_step_started,
  output logic                                  out_direction_out,
  output logic [COUNT_WIDTH-1:0]                out_steps_done,
  output logic [TIME_WIDTH-1:0]                 out_period_now_us
);

  stpg_pkg::stpg_cfg_t cfg;

  // input register
  logic                  in_valid_r, in_valid_nxt;
  logic                  func_r;
  logic [TIME_WIDTH-1:0] now_r;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic                   step_level_r;
  logic                   step_started_r;
  logic                   direction_r;
  logic [COUNT_WIDTH-1:0] steps_done_r;
  logic [TIME_WIDTH-1:0]  period_r;

  // core results for the transaction held in the input register
  logic                   core_level;
  logic                   core_started;
  logic [COUNT_WIDTH-1:0] core_steps;
  logic [TIME_WIDTH-1:0]  core_period;

  logic advance;
  logic in_take;

  stpg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // the held transaction moves on whenever the result register is free or
  // is being emptied this cycle; the core state updates on the same edge
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  stpg_step_core #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (advance),
    .func          (func_r),
    .now_us        (now_r),
    .cfg           (cfg),
    .step_level    (core_level),
    .step_started  (core_started),
    .steps_done    (core_steps),
    .period_now_us (core_period)
  );

  always_comb begin
    in_valid_nxt  = in_take || (in_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input payload capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r <= in_func;
      now_r  <= in_now_us;
    end
  end

  // result payload capture
  always_ff @(posedge clk) begin
    if (advance) begin
      step_level_r   <= core_level;
      step_started_r <= core_started;
      direction_r    <= cfg.move_direction ^ cfg.invert_direction;
      steps_done_r   <= core_steps;
      period_r       <= core_period;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_step_level    = step_level_r;
  assign out_step_started  = step_started_r;
  assign out_direction_out = direction_r;
  assign out_steps_done    = steps_done_r;
  assign out_period_now_us = period_r;

endmodule

`default_nettype wire

// File: tb/stepper_trapezoid_pulse_generator_tb.sv
// stepper_trapezoid_pulse_generator_tb: self-checking bench for the trapezoid step generator
// predicts every result transaction in a local model of the ramp and compares field by field
// depends on stpg_pkg and stepper_trapezoid_pulse_generator
`default_nettype none

module stepper_trapezoid_pulse_generator_tb;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 16;

  // input function codes
  localparam logic FUNC_TICK       = 1'b0;
  localparam logic FUNC_BEGIN_MOVE = 1'b1;

  // index with no register behind it, writes must be dropped
  localparam logic [stpg_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  // one input transaction; a tracked tick takes its time from the model state at
  // the moment it is presented (last step + current threshold + value as slack)
  typedef struct packed {
    logic              func;
    logic              tracked;
    logic [TIME_W-1:0] value;
  } tick_t;

  typedef struct packed {
    logic               step_level;
    logic               step_started;
    logic               direction_out;
    logic [COUNT_W-1:0] steps_done;
    logic [TIME_W-1:0]  period_now_us;
  } step_report_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [stpg_pkg::CFG_INDEX_W-1:0] cfg_index = stpg_pkg::REG_TOP_PERIOD;
  logic [stpg_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic                             in_func = FUNC_TICK;
  logic [TIME_W-1:0]                in_now_us = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             out_step_level;
  logic                             out_step_started;
  logic                             out_direction_out;
  logic [COUNT_W-1:0]               out_steps_done;
  logic [TIME_W-1:0]                out_period_now_us;

  // register copies as the block should hold them
  logic [stpg_pkg::TOP_PERIOD_W-1:0] top_period_q = stpg_pkg::TOP_PERIOD_RST;
  logic [stpg_pkg::MOVE_STEPS_W-1:0] move_steps_q = stpg_pkg::MOVE_STEPS_RST;
  logic                              move_dir_q = 1'b0;
  logic                              invert_q = 1'b0;
  logic [stpg_pkg::RAMP_STEPS_W-1:0] ramp_steps_q = stpg_pkg::RAMP_STEPS_RST;
  logic [stpg_pkg::RAMP_INC_W-1:0]   ramp_inc_q = stpg_pkg::RAMP_INC_RST;
  logic [stpg_pkg::PULSE_W-1:0]      pulse_width_q = stpg_pkg::PULSE_RST;

  // modeled motion state, starts at the reset values
  logic [TIME_W-1:0]  sim_last_step = '0;
  logic               sim_pulse_high = 1'b0;
  logic [TIME_W-1:0]  sim_period = 32'd1000;
  logic [COUNT_W-1:0] sim_count = '0;

  tick_t        ticks_pending[$];
  step_report_t reports_due[$];
  int           ticks_open = 0;  // queued or in flight, not yet checked
  int           errors = 0;
  logic         calm = 1'b0;     // no idling on either side while set

  stepper_trapezoid_pulse_generator #(
    .TIME_WIDTH  (TIME_W),
    .COUNT_WIDTH (COUNT_W)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_now_us         (in_now_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_step_level    (out_step_level),
    .out_step_started  (out_step_started),
    .out_direction_out (out_direction_out),
    .out_steps_done    (out_steps_done),
    .out_period_now_us (out_period_now_us)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [TIME_W-1:0] sat_time(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[TIME_W-1:0];
  endfunction

  // period a move starts at: cruise period plus the whole ramp
  function automatic logic [TIME_W-1:0] launch_period();
    logic [63:0] sum;
    sum = {40'd0, top_period_q} + {56'd0, ramp_steps_q} * {48'd0, ramp_inc_q};
    return sat_time(sum);
  endfunction

  // advances the modeled state by one tick and returns the result it causes
  function automatic step_report_t predict_tick(input logic func, input logic [TIME_W-1:0] now);
    step_report_t      r;
    logic [TIME_W-1:0] elapsed;
    logic [63:0]       count_w;
    logic [63:0]       ramp_w;
    logic [63:0]       steps_w;
    logic              started;
    started = 1'b0;
    if (func == FUNC_BEGIN_MOVE) begin
      sim_period = launch_period();
      sim_count  = '0;
    end
    elapsed = now - sim_last_step;  // wraps modulo 2^32
    if (!sim_pulse_high && elapsed >= sim_period) begin
      sim_pulse_high = 1'b1;
      sim_last_step  = now;
      started        = 1'b1;
    end else if (sim_pulse_high && elapsed >= {22'd0, pulse_width_q}) begin
      sim_pulse_high = 1'b0;
    end
    if (started) begin
      count_w = {48'd0, sim_count};
      ramp_w  = {56'd0, ramp_steps_q};
      steps_w = {48'd0, move_steps_q};
      // ramp-up only for moves longer than twice the ramp, strict compare on the count
      if (count_w < ramp_w && steps_w > 2 * ramp_w) begin
        sim_period = (sim_period >= {16'd0, ramp_inc_q}) ? sim_period - {16'd0, ramp_inc_q} : '0;
      end else if (count_w + ramp_w > steps_w) begin
        sim_period = sat_time({32'd0, sim_period} + {48'd0, ramp_inc_q});
      end
      if (sim_count != '1) begin
        sim_count = sim_count + 1'b1;
      end
    end
    r.step_level    = sim_pulse_high;
    r.step_started  = started;
    r.direction_out = move_dir_q ^ invert_q;
    r.steps_done    = sim_count;
    r.period_now_us = sim_period;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [TIME_W-1:0] want,
                                      input logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // driver: one pending tick per accepted transaction, random gaps between them
  always @(posedge clk) begin : drive
    tick_t             nxt;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] stamp;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        reports_due.push_back(predict_tick(in_func, in_now_us));
      end
      // a stalled transaction stays on the bus untouched
      if (!in_valid || !in_stall) begin
        if (ticks_pending.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
          nxt = ticks_pending.pop_front();
          if (nxt.tracked) begin
            // threshold the block compares against on this tick
            if (sim_pulse_high) begin
              gap = {22'd0, pulse_width_q};
            end else if (nxt.func == FUNC_BEGIN_MOVE) begin
              gap = launch_period();
            end else begin
              gap = sim_period;
            end
            stamp = sim_last_step + gap + nxt.value;
          end else begin
            stamp = nxt.value;
          end
          in_valid  <= 1'b1;
          in_func   <= nxt.func;
          in_now_us <= stamp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each accepted result against the oldest prediction
  always @(posedge clk) begin : watch
    step_report_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          $error("result transaction with no prediction waiting");
          errors++;
        end else begin
          want = reports_due.pop_front();
          check_field("step_level", {31'd0, want.step_level}, {31'd0, out_step_level});
          check_field("step_started", {31'd0, want.step_started}, {31'd0, out_step_started});
          check_field("direction_out", {31'd0, want.direction_out}, {31'd0, out_direction_out});
          check_field("steps_done", {16'd0, want.steps_done}, {16'd0, out_steps_done});
          check_field("period_now_us", want.period_now_us, out_period_now_us);
          ticks_open--;
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 33);
    end
  end

  task automatic queue_tick(input logic func, input logic tracked, input logic [TIME_W-1:0] value);
    tick_t t;
    t.func    = func;
    t.tracked = tracked;
    t.value   = value;
    ticks_pending.push_back(t);
    ticks_open++;
  endtask

  // wait until every queued tick has come back checked
  task automatic settle();
    while (ticks_open != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [stpg_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [stpg_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      stpg_pkg::REG_TOP_PERIOD:     top_period_q  = data[stpg_pkg::TOP_PERIOD_W-1:0];
      stpg_pkg::REG_MOVE_STEPS:     move_steps_q  = data[stpg_pkg::MOVE_STEPS_W-1:0];
      stpg_pkg::REG_MOVE_DIRECTION: move_dir_q    = data[0];
      stpg_pkg::REG_INVERT_DIR:     invert_q      = data[0];
      stpg_pkg::REG_RAMP_STEPS:     ramp_steps_q  = data[stpg_pkg::RAMP_STEPS_W-1:0];
      stpg_pkg::REG_RAMP_INCREMENT: ramp_inc_q    = data[stpg_pkg::RAMP_INC_W-1:0];
      stpg_pkg::REG_PULSE_WIDTH:    pulse_width_q = data[stpg_pkg::PULSE_W-1:0];
      default: ;
    endcase
  endtask

  // writes all seven registers, sometimes with junk above each field narrower than the data word
  task automatic program_move(input logic [23:0] top, input logic [15:0] steps, input logic dir,
                              input logic inv, input logic [7:0] ramp, input logic [15:0] inc,
                              input logic [9:0] pw);
    logic [stpg_pkg::CFG_DATA_W-1:0] junk;
    junk = ($urandom_range(3) == 0) ? (stpg_pkg::CFG_DATA_W)'($urandom) : '0;
    write_reg(stpg_pkg::REG_TOP_PERIOD, top);
    write_reg(stpg_pkg::REG_MOVE_STEPS, {junk[7:0], steps});
    write_reg(stpg_pkg::REG_MOVE_DIRECTION, {junk[22:0], dir});
    write_reg(stpg_pkg::REG_INVERT_DIR, {junk[23:1], inv});
    write_reg(stpg_pkg::REG_RAMP_STEPS, {junk[15:0], ramp});
    write_reg(stpg_pkg::REG_RAMP_INCREMENT, {junk[23:16], inc});
    write_reg(stpg_pkg::REG_PULSE_WIDTH, {junk[13:0], pw});
    if ($urandom_range(3) == 0) begin
      write_reg(REG_UNUSED, (stpg_pkg::CFG_DATA_W)'($urandom));
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    logic [23:0]       top;
    logic [15:0]       steps;
    logic [7:0]        ramp;
    logic [15:0]       inc;
    logic [9:0]        pw;
    logic [TIME_W-1:0] slack;
    int                pick;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: cruise 1000, ramp 16 x 100, pulse 10, zero-length move
    queue_tick(FUNC_TICK, 1'b0, 32'd0);
    queue_tick(FUNC_TICK, 1'b0, 32'd999);         // one short of the period
    queue_tick(FUNC_TICK, 1'b0, 32'd1000);        // exactly one period: step
    queue_tick(FUNC_TICK, 1'b0, 32'd1009);        // pulse still inside its width
    queue_tick(FUNC_TICK, 1'b0, 32'd1010);        // pulse falls
    queue_tick(FUNC_TICK, 1'b1, 32'hFFFF_FFFF);   // one short, tracked
    queue_tick(FUNC_TICK, 1'b1, 32'd0);
    queue_tick(FUNC_BEGIN_MOVE, 1'b1, 32'hFFFF_FFF7); // new move while the pulse is high
    queue_tick(FUNC_TICK, 1'b1, 32'd0);
    queue_tick(FUNC_TICK, 1'b1, 32'd0);
    queue_tick(FUNC_TICK, 1'b0, 32'hFFFF_FFFF);
    queue_tick(FUNC_BEGIN_MOVE, 1'b0, 32'hFFFF_FFFF);
    queue_tick(FUNC_TICK, 1'b0, 32'd5);           // time wrapped, pulse still high
    queue_tick(FUNC_TICK, 1'b0, 32'd9);           // width reached across the wrap
    queue_tick(FUNC_TICK, 1'b0, 32'h5555_5555);
    queue_tick(FUNC_BEGIN_MOVE, 1'b0, 32'hAAAA_AAAA);
    settle();

    // zero period and zero width: step on every low tick, fall on the next
    program_move(24'd0, 16'hFFFF, 1'b1, 1'b0, 8'd0, 16'd0, 10'd0);
    queue_tick(FUNC_BEGIN_MOVE, 1'b0, 32'h1234_5678);
    repeat (3) queue_tick(FUNC_TICK, 1'b0, 32'h1234_5678);
    settle();
    program_move(24'd0, 16'hFFFF, 1'b1, 1'b1, 8'd0, 16'd0, 10'd0);
    repeat (2) queue_tick(FUNC_TICK, 1'b1, 32'd0);
    settle();

    // ramp made longer mid-move: ramp-up from a short period must stop at zero
    program_move(24'd5, 16'd100, 1'b0, 1'b1, 8'd0, 16'd7, 10'd1);
    queue_tick(FUNC_BEGIN_MOVE, 1'b1, 32'd0);
    settle();
    program_move(24'd5, 16'd100, 1'b0, 1'b1, 8'd10, 16'd7, 10'd1);
    repeat (5) queue_tick(FUNC_TICK, 1'b1, 32'd0);
    settle();

    // random moves, first all-max then all-zero settings
    for (int phase = 0; phase < 16; phase++) begin
      if (phase == 0) begin
        program_move(24'hFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 8'hFF, 16'hFFFF, 10'h3FF);
      end else if (phase == 1) begin
        program_move(24'd0, 16'd0, 1'b0, 1'b0, 8'd0, 16'd0, 10'd0);
      end else begin
        pick = $urandom_range(5);
        top = (pick == 0) ? 24'd0 : (pick == 1) ? 24'($urandom) : 24'($urandom_range(80, 1));
        pick = $urandom_range(4);
        ramp = (pick == 0) ? 8'd0 : (pick == 1) ? 8'hFF : 8'($urandom_range(12, 1));
        pick = $urandom_range(4);
        inc = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom) : 16'($urandom_range(20, 1));
        pick = $urandom_range(4);
        pw = (pick == 0) ? 10'd0 : (pick == 1) ? 10'h3FF : 10'($urandom_range(30, 1));
        // move lengths right at the ramp-up limit are the interesting ones
        case ($urandom_range(4))
          0:       steps = {7'd0, ramp, 1'b0};
          1:       steps = {7'd0, ramp, 1'b1};
          2:       steps = 16'($urandom);
          default: steps = 16'($urandom_range(80));
        endcase
        program_move(top, steps, 1'($urandom), 1'($urandom), ramp, inc, pw);
      end
      if ($urandom_range(7) != 0) begin
        queue_tick(FUNC_BEGIN_MOVE, 1'b1, 32'd0);
      end
      for (int n = 0; n < 80; n++) begin
        pick = $urandom_range(99);
        case ($urandom_range(19))
          0:       slack = -32'($urandom_range(1000, 1));  // well short of the threshold
          1, 2, 3: slack = 32'($urandom_range(4)) - 32'd2;
          4:       slack = 32'($urandom_range(500));
          default: slack = 32'd0;
        endcase
        if (pick < 6) begin
          queue_tick(1'($urandom), 1'b0, 32'($urandom));    // time jumps anywhere
        end else if (pick < 10) begin
          queue_tick(FUNC_BEGIN_MOVE, 1'b1, slack);
        end else begin
          queue_tick(FUNC_TICK, 1'b1, slack);
        end
      end
      settle();
    end

    // long run with no idling: slowest ramp-down, one step every two ticks
    calm = 1'b1;
    program_move(24'hFF_FFFF, 16'd0, 1'b1, 1'b0, 8'd0, 16'hFFFF, 10'd0);
    queue_tick(FUNC_BEGIN_MOVE, 1'b1, 32'd0);
    for (int n = 0; n < 300; n++) begin
      queue_tick(FUNC_TICK, 1'b1, ($urandom_range(255) == 0) ? 32'hFFFF_FFFF : 32'd0);
    end
    settle();
    calm = 1'b0;

    // let the two-stage pipe show anything stray
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS stepper_trapezoid_pulse_generator");
    end else begin
      $display("FAIL stepper_trapezoid_pulse_generator");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin : watchdog
    #4_000_000;
    $display("FAIL stepper_trapezoid_pulse_generator");
    $finish;
  end

endmodule

`default_nettype wire
